// File: hdl/dct_pkg.sv
// ----------------------------------------------------------------------------
// dct_pkg
// Shared types, constants and helpers for the DRAM command timing checker.
// ----------------------------------------------------------------------------
package dct_pkg;

    // widest rank and bank index that any configuration may need
    localparam int RANK_MAX_W = 3;
    localparam int BANK_MAX_W = 4;

    // signed width of a timing term: 32-bit age plus summed byte offsets
    localparam int TERM_W = 36;

    localparam int GAP_W   = 12;
    localparam int GAP_MAX = 4095;

    // age given to "other rank" times when no other rank exists
    localparam int NO_CAS_AGE = 1000;

    // opcodes
    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_RECORD = 1'b1;

    // command kinds
    typedef enum logic [2:0] {
        CMD_ACT     = 3'd0,
        CMD_RD      = 3'd1,
        CMD_RDA     = 3'd2,
        CMD_WR      = 3'd3,
        CMD_WRA     = 3'd4,
        CMD_PRE     = 3'd5,
        CMD_REF     = 3'd6,
        CMD_OTHER   = 3'd7
    } cmd_kind_t;

    // register indexes
    localparam logic [2:0] REG_ACT  = 3'd0;
    localparam logic [2:0] REG_RFC  = 3'd1;
    localparam logic [2:0] REG_CAS  = 3'd2;
    localparam logic [2:0] REG_BST  = 3'd3;
    localparam logic [2:0] REG_PRE  = 3'd4;
    localparam logic [2:0] REG_RNK  = 3'd5;

    typedef logic signed [TERM_W-1:0] term_t;

    // one queued request, after index reduction
    typedef struct packed {
        logic                  op;
        cmd_kind_t             kind;
        logic [RANK_MAX_W-1:0] rank;
        logic [BANK_MAX_W-1:0] bank;
        logic [31:0]           now;
    } item_t;

    // decoded timing configuration
    typedef struct packed {
        logic [7:0] t_rc;
        logic [7:0] t_rrd;
        logic [7:0] t_rp;
        logic [7:0] t_faw;
        logic [9:0] t_rfc;
        logic [7:0] t_rcd;
        logic [7:0] t_al;
        logic [7:0] t_cas;
        logic [7:0] t_cwd;
        logic [7:0] t_burst;
        logic [7:0] t_wtr;
        logic [7:0] t_rtrs;
        logic [7:0] t_ost;
        logic [7:0] t_ras;
        logic [7:0] t_rtp;
        logic [7:0] t_wr;
        logic [7:0] t_cmd;
        logic [2:0] ranks_in_use;
    } cfg_t;

    // wrapping signed difference t - now, sign extended
    function automatic term_t age(input logic [31:0] t, input logic [31:0] now);
        logic [31:0] d;
        d = t - now;
        return term_t'(signed'(d));
    endfunction

    // zero-extended timing value as a term
    function automatic term_t tv(input logic [9:0] v);
        return term_t'({1'b0, v});
    endfunction

endpackage

// File: hdl/dct_front.sv
// ----------------------------------------------------------------------------
// dct_front
// Accepts requests, reduces rank and bank indexes and queues them (2 deep).
// ----------------------------------------------------------------------------
module dct_front import dct_pkg::*; #(
    parameter int RANKS = 4,
    parameter int BANKS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_op,
    input  logic [2:0]  in_kind,
    input  logic [1:0]  in_rank,
    input  logic [2:0]  in_bank,
    input  logic [31:0] in_now,
    output logic        q_valid,
    input  logic        q_pop,
    output item_t       q_item
);

    item_t       slot_reg [2];
    logic        wptr_reg, wptr_next;
    logic        rptr_reg, rptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    item_t       item_in;
    logic        push;

    // rank modulo RANKS by repeated subtract (input is 2 bits)
    function automatic logic [RANK_MAX_W-1:0] rank_mod(input logic [1:0] v);
        logic [RANK_MAX_W-1:0] x;
        x = RANK_MAX_W'(v);
        for (int k = 0; k < 4; k++) begin
            if (int'(x) >= RANKS) x = x - RANK_MAX_W'(RANKS);
        end
        return x;
    endfunction

    // bank modulo BANKS (input is 3 bits)
    function automatic logic [BANK_MAX_W-1:0] bank_mod(input logic [2:0] v);
        logic [BANK_MAX_W-1:0] x;
        x = BANK_MAX_W'(v);
        for (int k = 0; k < 8; k++) begin
            if (int'(x) >= BANKS) x = x - BANK_MAX_W'(BANKS);
        end
        return x;
    endfunction

    // classify incoming request
    always_comb begin
        item_in.op   = in_op;
        item_in.kind = cmd_kind_t'(in_kind);
        item_in.rank = rank_mod(in_rank);
        item_in.bank = bank_mod(in_bank);
        item_in.now  = in_now;
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rptr_reg];

    // queue pointers
    always_comb begin
        wptr_next = push  ? ~wptr_reg : wptr_reg;
        rptr_next = q_pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) slot_reg[wptr_reg] <= item_in;
    end

endmodule

// File: hdl/dct_back.sv
// ----------------------------------------------------------------------------
// dct_back
// Holds the timestamp state, records issued commands and evaluates queries:
// other-rank scan, term build, serial max reduction.
// ----------------------------------------------------------------------------
module dct_back import dct_pkg::*; #(
    parameter int RANKS      = 4,
    parameter int BANKS      = 8,
    parameter int ACT_WINDOW = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             q_valid,
    output logic             q_pop,
    input  item_t            q_item,
    output logic             res_valid,
    input  logic             res_ready,
    output logic [GAP_W-1:0] res_gap
);

    localparam int NB  = RANKS * BANKS;
    localparam int RW  = (RANKS > 1) ? $clog2(RANKS) : 1;
    localparam int BW  = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int BIW = (NB > 1) ? $clog2(NB) : 1;
    localparam int CW  = $clog2(ACT_WINDOW + 1);
    localparam int NT  = 6;
    localparam int KW  = $clog2(NT);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_TERM = 5'b00100,
        ST_MAX  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // per-bank timestamp memories with valid bits
    logic [31:0] mem_act [NB];
    logic [31:0] mem_pre [NB];
    logic [31:0] mem_rd  [NB];
    logic [31:0] mem_wr  [NB];
    logic [NB-1:0] vld_act_reg, vld_pre_reg, vld_rd_reg, vld_wr_reg;
    logic [31:0] rd_act_reg, rd_pre_reg, rd_rd_reg, rd_wr_reg;
    logic        v_act_reg, v_pre_reg, v_rd_reg, v_wr_reg;
    logic [31:0] b_act, b_pre, b_rd, b_wr;

    // per-rank timestamps
    logic [31:0] rk_rd_reg  [RANKS];
    logic [31:0] rk_wr_reg  [RANKS];
    logic [31:0] rk_ref_reg [RANKS];
    logic [31:0] rk_pre_reg [RANKS];
    logic [31:0] hist_reg   [RANKS][ACT_WINDOW];
    logic [CW-1:0] hcnt_reg [RANKS];
    logic [31:0] last_reg;

    // working registers
    item_t          cur_reg;
    logic [RW-1:0]  sc_reg;
    term_t          ord_reg, owr_reg;
    term_t          term_reg [NT];
    logic [KW-1:0]  k_reg;
    term_t          acc_reg;
    logic [GAP_W-1:0] gap_reg;

    logic [RW-1:0]  h_r, c_r;
    logic [BW-1:0]  h_b;
    logic [BIW-1:0] h_bi, c_bi;
    logic           start, is_rec;

    assign h_r    = q_item.rank[RW-1:0];
    assign h_b    = q_item.bank[BW-1:0];
    assign h_bi   = BIW'(int'(h_r) * BANKS + int'(h_b));
    assign c_r    = cur_reg.rank[RW-1:0];
    assign c_bi   = BIW'(int'(c_r) * BANKS + int'(cur_reg.bank[BW-1:0]));
    assign start  = (state_reg == ST_IDLE) && q_valid;
    assign is_rec = start && (q_item.op == OP_RECORD);
    assign q_pop  = start;

    // bank memories: write on record, read the current query's bank every cycle
    always_ff @(posedge aclk) begin
        if (is_rec && q_item.kind == CMD_ACT) mem_act[h_bi] <= q_item.now;
        if (is_rec && q_item.kind == CMD_PRE) mem_pre[h_bi] <= q_item.now;
        if (is_rec && (q_item.kind == CMD_RD || q_item.kind == CMD_RDA))
            mem_rd[h_bi] <= q_item.now;
        if (is_rec && (q_item.kind == CMD_WR || q_item.kind == CMD_WRA))
            mem_wr[h_bi] <= q_item.now;
        rd_act_reg <= mem_act[c_bi];
        rd_pre_reg <= mem_pre[c_bi];
        rd_rd_reg  <= mem_rd[c_bi];
        rd_wr_reg  <= mem_wr[c_bi];
        v_act_reg  <= vld_act_reg[c_bi];
        v_pre_reg  <= vld_pre_reg[c_bi];
        v_rd_reg   <= vld_rd_reg[c_bi];
        v_wr_reg   <= vld_wr_reg[c_bi];
    end

    assign b_act = v_act_reg ? rd_act_reg : 32'd0;
    assign b_pre = v_pre_reg ? rd_pre_reg : 32'd0;
    assign b_rd  = v_rd_reg  ? rd_rd_reg  : 32'd0;
    assign b_wr  = v_wr_reg  ? rd_wr_reg  : 32'd0;

    // valid bits and rank state, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_act_reg <= '0;
            vld_pre_reg <= '0;
            vld_rd_reg  <= '0;
            vld_wr_reg  <= '0;
            last_reg    <= 32'd0;
            for (int i = 0; i < RANKS; i++) begin
                rk_rd_reg[i]  <= 32'd0;
                rk_wr_reg[i]  <= 32'd0;
                rk_ref_reg[i] <= 32'd0;
                rk_pre_reg[i] <= 32'd0;
                hcnt_reg[i]   <= '0;
            end
        end else if (is_rec) begin
            last_reg <= q_item.now;
            unique case (q_item.kind)
                CMD_ACT: begin
                    vld_act_reg[h_bi] <= 1'b1;
                    if (int'(hcnt_reg[h_r]) < ACT_WINDOW)
                        hcnt_reg[h_r] <= hcnt_reg[h_r] + CW'(1);
                end
                CMD_RD, CMD_RDA: begin
                    vld_rd_reg[h_bi] <= 1'b1;
                    rk_rd_reg[h_r]   <= q_item.now;
                end
                CMD_WR, CMD_WRA: begin
                    vld_wr_reg[h_bi] <= 1'b1;
                    rk_wr_reg[h_r]   <= q_item.now;
                end
                CMD_PRE: begin
                    vld_pre_reg[h_bi] <= 1'b1;
                    rk_pre_reg[h_r]   <= q_item.now;
                end
                CMD_REF: rk_ref_reg[h_r] <= q_item.now;
                default: ;
            endcase
        end
    end

    // activate history shift line, newest at entry 0
    always_ff @(posedge aclk) begin
        if (is_rec && q_item.kind == CMD_ACT) begin
            for (int j = ACT_WINDOW - 1; j > 0; j--)
                hist_reg[h_r][j] <= hist_reg[h_r][j-1];
            hist_reg[h_r][0] <= q_item.now;
        end
    end

    // term build for the current query
    function automatic void build_terms(output term_t t [NT]);
        term_t neg, a_act, rrd, rwr, lst;
        logic  multi;
        neg   = {1'b1, {(TERM_W-1){1'b0}}};
        a_act = age(b_act, cur_reg.now);
        rrd   = age(rk_rd_reg[c_r], cur_reg.now);
        rwr   = age(rk_wr_reg[c_r], cur_reg.now);
        lst   = age(last_reg, cur_reg.now) + tv(10'(cfg.t_cmd));
        multi = (cfg.ranks_in_use > 3'd1);
        for (int i = 0; i < NT; i++) t[i] = neg;
        t[NT-1] = lst;
        unique case (cur_reg.kind)
            CMD_ACT: begin
                t[0] = age(rk_ref_reg[c_r], cur_reg.now) + tv(cfg.t_rfc);
                t[1] = a_act + tv(10'(cfg.t_rc));
                t[2] = age(b_pre, cur_reg.now) + tv(10'(cfg.t_rp));
                if (hcnt_reg[c_r] != '0)
                    t[3] = age(hist_reg[c_r][0], cur_reg.now) + tv(10'(cfg.t_rrd));
                if (int'(hcnt_reg[c_r]) >= ACT_WINDOW)
                    t[4] = age(hist_reg[c_r][ACT_WINDOW-1], cur_reg.now)
                         + tv(10'(cfg.t_faw));
            end
            CMD_RD, CMD_RDA: begin
                t[0] = rrd + tv(10'(cfg.t_burst));
                t[1] = rwr + tv(10'(cfg.t_cwd)) + tv(10'(cfg.t_burst))
                     + tv(10'(cfg.t_wtr));
                if (multi) begin
                    t[2] = ord_reg + tv(10'(cfg.t_burst)) + tv(10'(cfg.t_rtrs));
                    t[3] = owr_reg + tv(10'(cfg.t_cwd)) + tv(10'(cfg.t_burst))
                         + tv(10'(cfg.t_rtrs)) - tv(10'(cfg.t_cas));
                end
                t[4] = a_act + tv(10'(cfg.t_rcd)) - tv(10'(cfg.t_al));
            end
            CMD_WR, CMD_WRA: begin
                t[0] = rrd + tv(10'(cfg.t_cas)) + tv(10'(cfg.t_burst))
                     + tv(10'(cfg.t_rtrs)) - tv(10'(cfg.t_cwd));
                t[1] = ord_reg + tv(10'(cfg.t_cas)) + tv(10'(cfg.t_burst))
                     + tv(10'(cfg.t_rtrs)) - tv(10'(cfg.t_cwd));
                t[2] = rwr + tv(10'(cfg.t_burst));
                t[3] = owr_reg + tv(10'(cfg.t_burst)) + tv(10'(cfg.t_ost));
                t[4] = a_act + tv(10'(cfg.t_rcd)) - tv(10'(cfg.t_al));
            end
            CMD_PRE: begin
                t[0] = age(b_rd, cur_reg.now) + tv(10'(cfg.t_cas))
                     + tv(10'(cfg.t_burst))
                     + ((cfg.t_rtp > cfg.t_cmd) ? tv(10'(cfg.t_rtp - cfg.t_cmd)) : '0);
                t[1] = age(b_wr, cur_reg.now) + tv(10'(cfg.t_cwd))
                     + tv(10'(cfg.t_burst)) + tv(10'(cfg.t_wr));
                t[2] = a_act + tv(10'(cfg.t_ras));
            end
            CMD_REF: begin
                t[0] = age(rk_ref_reg[c_r], cur_reg.now) + tv(cfg.t_rfc);
                t[1] = age(rk_pre_reg[c_r], cur_reg.now) + tv(10'(cfg.t_rp));
            end
            default: ;
        endcase
    endfunction

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (q_valid) state_next = is_rec ? ST_DONE : ST_SCAN;
            ST_SCAN: if (int'(sc_reg) == RANKS - 1) state_next = ST_TERM;
            ST_TERM: state_next = ST_MAX;
            ST_MAX:  if (int'(k_reg) == NT - 1) state_next = ST_DONE;
            ST_DONE: if (res_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // datapath of the sequencer
    always_ff @(posedge aclk) begin
        term_t tt [NT];
        term_t ar, aw;
        unique case (state_reg)
            ST_IDLE: begin
                cur_reg <= q_item;
                sc_reg  <= '0;
                ord_reg <= -term_t'(NO_CAS_AGE);
                owr_reg <= -term_t'(NO_CAS_AGE);
                gap_reg <= '0;
            end
            ST_SCAN: begin
                // one other rank per cycle, strictly newer wins
                ar = age(rk_rd_reg[sc_reg], cur_reg.now);
                aw = age(rk_wr_reg[sc_reg], cur_reg.now);
                if (int'(sc_reg) < int'(cfg.ranks_in_use) && sc_reg != c_r) begin
                    if (ar > ord_reg) ord_reg <= ar;
                    if (aw > owr_reg) owr_reg <= aw;
                end
                if (int'(sc_reg) != RANKS - 1) sc_reg <= sc_reg + RW'(1);
            end
            ST_TERM: begin
                build_terms(tt);
                for (int i = 0; i < NT; i++) term_reg[i] <= tt[i];
                k_reg   <= '0;
                acc_reg <= '0;
            end
            ST_MAX: begin
                // running max, floor at zero, clamp on the last term
                if (int'(k_reg) == NT - 1) begin
                    if (((term_reg[k_reg] > acc_reg) ? term_reg[k_reg] : acc_reg)
                        > term_t'(GAP_MAX))
                        gap_reg <= GAP_W'(GAP_MAX);
                    else if (term_reg[k_reg] > acc_reg)
                        gap_reg <= term_reg[k_reg][GAP_W-1:0];
                    else
                        gap_reg <= acc_reg[GAP_W-1:0];
                end else begin
                    if (term_reg[k_reg] > acc_reg) acc_reg <= term_reg[k_reg];
                    k_reg <= k_reg + KW'(1);
                end
            end
            default: ;
        endcase
    end

    assign res_valid = (state_reg == ST_DONE);
    assign res_gap   = gap_reg;

endmodule

// File: hdl/dram_command_timing_checker.sv
// ----------------------------------------------------------------------------
// dram_command_timing_checker
// DRAM command timing checker: answers minimum issue gaps, records commands.
// ----------------------------------------------------------------------------
//  channel  | dir | ports                 | payload
//  s_       | in  | tvalid/tready/tdata/tuser | request: rank, bank, now; opcode, kind
//  m_       | out | tvalid/tready/tdata   | min_gap
//  apb      | in  | psel..prdata          | six configuration registers
//
//  A query runs through the back end in steps: one per rank of the
//  other-rank scan, one term build, six steps of the serial max reduction.
//  A record goes from idle straight to done. The front queue holds two
//  requests, and the output register lets the next request start while a
//  result waits. Reset is synchronous, active low; bank timestamps read
//  as zero through valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module dram_command_timing_checker import dct_pkg::*; #(
    parameter int RANKS      = 4,
    parameter int BANKS      = 8,
    parameter int ACT_WINDOW = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // rank_index[1:0], bank_index[4:2], now[36:5], zero
    input  logic [3:0]  s_tuser,   // opcode[0], command_kind[3:1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // min_gap[11:0], zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] act_reg, cas_reg, bst_reg, pre_reg;
    logic [9:0]  rfc_reg;
    logic [2:0]  rnk_reg;
    logic        wr_en;
    cfg_t        cfg;
    logic        q_valid, q_pop;
    item_t       q_item;
    logic        res_valid, res_ready;
    logic [GAP_W-1:0] res_gap;
    logic        mv_reg;
    logic [GAP_W-1:0] md_reg;

    // configuration registers
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= 32'd0;
            rfc_reg <= 10'd0;
            cas_reg <= 32'd0;
            bst_reg <= 32'd0;
            pre_reg <= 32'd0;
            rnk_reg <= 3'd1;
        end else if (wr_en) begin
            unique case (paddr[4:2])
                REG_ACT: act_reg <= pwdata;
                REG_RFC: rfc_reg <= pwdata[9:0];
                REG_CAS: cas_reg <= pwdata;
                REG_BST: bst_reg <= pwdata;
                REG_PRE: pre_reg <= pwdata;
                REG_RNK: rnk_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (paddr[4:2])
            REG_ACT: prdata = act_reg;
            REG_RFC: prdata = {22'd0, rfc_reg};
            REG_CAS: prdata = cas_reg;
            REG_BST: prdata = bst_reg;
            REG_PRE: prdata = pre_reg;
            REG_RNK: prdata = {29'd0, rnk_reg};
            default: prdata = 32'd0;
        endcase
    end

    // timing fields
    always_comb begin
        cfg.t_rc         = act_reg[7:0];
        cfg.t_rrd        = act_reg[15:8];
        cfg.t_rp         = act_reg[23:16];
        cfg.t_faw        = act_reg[31:24];
        cfg.t_rfc        = rfc_reg;
        cfg.t_rcd        = cas_reg[7:0];
        cfg.t_al         = cas_reg[15:8];
        cfg.t_cas        = cas_reg[23:16];
        cfg.t_cwd        = cas_reg[31:24];
        cfg.t_burst      = bst_reg[7:0];
        cfg.t_wtr        = bst_reg[15:8];
        cfg.t_rtrs       = bst_reg[23:16];
        cfg.t_ost        = bst_reg[31:24];
        cfg.t_ras        = pre_reg[7:0];
        cfg.t_rtp        = pre_reg[15:8];
        cfg.t_wr         = pre_reg[23:16];
        cfg.t_cmd        = pre_reg[31:24];
        cfg.ranks_in_use = rnk_reg;
    end

    dct_front #(.RANKS(RANKS), .BANKS(BANKS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tuser[0]),
        .in_kind  (s_tuser[3:1]),
        .in_rank  (s_tdata[1:0]),
        .in_bank  (s_tdata[4:2]),
        .in_now   (s_tdata[36:5]),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    dct_back #(.RANKS(RANKS), .BANKS(BANKS), .ACT_WINDOW(ACT_WINDOW)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_gap   (res_gap)
    );

    // output register
    assign res_ready = !mv_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) mv_reg <= 1'b0;
        else if (res_ready) mv_reg <= res_valid;
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) md_reg <= res_gap;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {4'd0, md_reg};

endmodule

// File: hdl/dct_checker.sv
// ----------------------------------------------------------------------------
// dct_checker
// Port-level checks for the DRAM command timing checker.
// ----------------------------------------------------------------------------
module dct_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        pready
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    // no result right out of reset
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // pad bits of the result stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:12] == 4'd0)
        else $error("result pad bits set");

    // handshake lines are always driven to known levels
    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        !$isunknown({s_tvalid, s_tready, m_tvalid}))
        else $error("handshake line unknown");

    // config port never waits
    a_rdy: assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind dram_command_timing_checker dct_checker u_dct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
